@@ rtl/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned OPC_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned POS_W = 11;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_EXACT = 2'd1,
    OP_FLOOR = 2'd2,
    OP_CEIL  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic probe;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_search;
    logic cont;
  } status_t;

endpackage

@@ rtl/stbs_ram.sv @@
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for the search: accept, probe, step, deliver.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  stbs_pkg::status_t status_i,
  output stbs_pkg::cmd_t    cmd_o
);

  stbs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.in_search) begin
          state_d = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_PROBE: begin
        state_d = status_i.cont ? stbs_pkg::ST_WAIT : stbs_pkg::ST_DONE;
      end
      stbs_pkg::ST_WAIT: begin
        state_d = stbs_pkg::ST_PROBE;
      end
      stbs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      default: state_d = stbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      stbs_pkg::ST_PROBE: cmd_o.probe    = status_i.cont;
      stbs_pkg::ST_WAIT:  cmd_o.step     = 1'b1;
      stbs_pkg::ST_DONE:  cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/stbs_datapath.sv @@
// ----------------------------------------------------------------------------
// stbs_datapath
// Window bounds, midpoint, key compare, table RAM and result register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic        [stbs_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic        [stbs_pkg::OPC_W-1:0]   opcode_i,
  input  logic        [stbs_pkg::IDX_W-1:0]   entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0]   entry_value_i,
  input  logic signed [stbs_pkg::VAL_W-1:0]   search_key_i,
  input  stbs_pkg::cmd_t                      cmd_i,
  output stbs_pkg::status_t                   status_o,
  output logic signed [stbs_pkg::POS_W-1:0]   position_o,
  output logic                                found_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 2;
  localparam int unsigned XW = 32;

  stbs_pkg::opcode_e opcode;
  logic [stbs_pkg::CNT_W-1:0] count_q;
  logic signed [CW-1:0] count_eff;
  logic signed [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid;
  logic signed [CW-1:0] diff, res_d;
  logic signed [stbs_pkg::VAL_W-1:0] key_q, rd_data;
  logic exact_q, floor_q, match_q, match_d;
  logic signed [stbs_pkg::POS_W-1:0] pos_q;
  logic found_q;
  logic wr_en, key_eq, key_gt;

  assign opcode = stbs_pkg::opcode_e'(opcode_i);

  assign count_eff = (XW'(count_q) > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                       : CW'(count_q);

  assign diff = hi_q - lo_q;
  assign mid  = lo_q + (diff >>> 1);

  assign key_eq = (key_q == rd_data);
  assign key_gt = (key_q > rd_data);

  assign status_o.in_search = (opcode != stbs_pkg::OP_LOAD);
  assign status_o.cont = exact_q ? ((lo_q <= hi_q) && !match_q) : (diff > CW'(1));

  assign wr_en = cmd_i.take && (opcode == stbs_pkg::OP_LOAD) &&
                 (XW'(entry_index_i) < XW'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (stbs_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(entry_index_i)),
    .wr_data_i (entry_value_i),
    .rd_en_i   (cmd_i.probe),
    .rd_addr_i (mid[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    match_d = match_q;
    if (cmd_i.take) begin
      lo_d    = (opcode == stbs_pkg::OP_EXACT) ? CW'(0) : -CW'(1);
      hi_d    = count_eff - CW'(1);
      match_d = 1'b0;
    end else if (cmd_i.step) begin
      if (exact_q) begin
        if (key_eq) begin
          match_d = 1'b1;
        end else if (key_gt) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q - CW'(1);
        end
      end else if (key_gt) begin
        lo_d = mid_q;
      end else begin
        hi_d = mid_q;
      end
    end
  end

  always_comb begin
    if (match_q) begin
      res_d = mid_q;
    end else if (exact_q) begin
      res_d = -CW'(1);
    end else if (floor_q) begin
      res_d = (hi_q < 0) ? -CW'(1) : hi_q - CW'(1);
    end else begin
      res_d = hi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      match_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        count_q <= cfg_data_i;
      end
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.take) begin
      key_q   <= search_key_i;
      exact_q <= (opcode == stbs_pkg::OP_EXACT);
      floor_q <= (opcode == stbs_pkg::OP_FLOOR);
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
    end
    if (cmd_i.out_load) begin
      pos_q   <= stbs_pkg::POS_W'(res_d);
      found_q <= !res_d[CW-1];
    end
  end

  assign position_o = pos_q;
  assign found_o    = found_q;

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words searched by binary search (exact, floor, ceil).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per item:
//   opcode, entry index, entry value and search key. A load writes one
//   table entry when it is accepted and gives no result. A search gives one
//   result word on the output channel (out_valid_o / out_ready_i).
//   Config channel (cfg_valid_i / cfg_ready_o) writes the entry count;
//   write it only while no search is in flight. The count is capped at
//   TABLE_DEPTH.
//   Each probe of the table RAM sets the address in ST_PROBE, then
//   compares the registered read data in ST_WAIT. A search is accepted
//   in ST_IDLE and loads its result in ST_DONE once the output is free.
//   The probe loop runs over the single RAM read port.
//   Input is accepted while a result waits; a stalled receiver holds the
//   result register, and a following search waits at its end for it.
//   Reset clears the count to zero and empties the output; the table
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [stbs_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic        [stbs_pkg::OPC_W-1:0] opcode_i,
  input  logic        [stbs_pkg::IDX_W-1:0] entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] search_key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [stbs_pkg::POS_W-1:0] position_o,
  output logic                              found_o
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_write_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .position_o    (position_o),
    .found_o       (found_o)
  );

endmodule

@@ rtl/stbs_checker.sv @@
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic        [stbs_pkg::OPC_W-1:0] opcode_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [stbs_pkg::POS_W-1:0] position_i,
  input logic                              found_i
);

  a_not_found_is_minus_one: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !found_i) |-> (position_i == -stbs_pkg::POS_W'(1))
  ) else $error("result without a match does not read minus one");

  a_search_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (opcode_i != stbs_pkg::OP_LOAD)) |=> !in_ready_i
  ) else $error("new word taken while a search is running");

  a_load_one_cycle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (opcode_i == stbs_pkg::OP_LOAD)) |=> in_ready_i
  ) else $error("load word did not complete in one cycle");

  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(position_i) && $stable(found_i))
  ) else $error("stalled result word changed");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .opcode_i    (opcode_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_i  (position_o),
  .found_i     (found_o)
);

@@ test/stbs_search_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stbs_search_checker
// Watches the config, input and result channels of the sorted table search
// block, keeps its own copy of the table and the entry count, works out the
// index each search should return and compares every result word with it.
// ----------------------------------------------------------------------------
module stbs_search_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic        [stbs_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic        [stbs_pkg::OPC_W-1:0] opcode_i,
  input  logic        [stbs_pkg::IDX_W-1:0] entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] search_key_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [stbs_pkg::POS_W-1:0] position_i,
  input  logic                              found_i,
  output int                                error_count_o,
  output int                                pending_o
);

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [stbs_pkg::POS_W-1:0] position;
    logic                       found;
  } search_result_t;

  logic signed [stbs_pkg::VAL_W-1:0] table_q [DEPTH];
  logic        [stbs_pkg::CNT_W-1:0] entry_count_q;
  search_result_t                    expected_q [$];
  search_result_t                    want;
  int                                hit;

  function automatic int live_entries();
    return (entry_count_q > DEPTH) ? DEPTH : int'(entry_count_q);
  endfunction

  function automatic int exact_index(logic signed [stbs_pkg::VAL_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = live_entries() - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key == table_q[mid]) return mid;
      if (key > table_q[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // last entry is never compared, so the answer is capped at count-1
  function automatic int lower_bound_index(logic signed [stbs_pkg::VAL_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = -1;
    hi = live_entries() - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (key > table_q[mid]) lo = mid;
      else hi = mid;
    end
    return hi;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) entry_count_q = cfg_data_i;

      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: position %0d, found %0b", position_i, found_i);
          error_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (position_i !== want.position) begin
            $error("position: expected %0d, actual %0d", $signed(want.position), position_i);
            error_count_o++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found_i);
            error_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (stbs_pkg::opcode_e'(opcode_i))
          stbs_pkg::OP_LOAD: begin
            if (entry_index_i < DEPTH) table_q[entry_index_i] = entry_value_i;
          end
          stbs_pkg::OP_EXACT: hit = exact_index(search_key_i);
          stbs_pkg::OP_CEIL:  hit = lower_bound_index(search_key_i);
          default: begin
            if (live_entries() == 0) hit = -1;
            else hit = lower_bound_index(search_key_i) - 1;
          end
        endcase
        if (stbs_pkg::opcode_e'(opcode_i) != stbs_pkg::OP_LOAD) begin
          want.position = stbs_pkg::POS_W'(hit);
          want.found    = (hit >= 0);
          expected_q.insert(expected_q.size(), want);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ test/tb_sorted_table_binary_search.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Loads ascending (and some unordered) tables, runs exact, floor and ceil
// searches against them under random sender gaps and receiver stalls, and
// sweeps the entry count from empty to beyond the table depth.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;

  localparam int DEPTH  = 1024;
  localparam int VAL_LO = 32'sh8000_0000;
  localparam int VAL_HI = 32'sh7fff_ffff;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic        [stbs_pkg::CNT_W-1:0]  cfg_data_i    = '0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_ready_o;
  logic        [stbs_pkg::OPC_W-1:0]  opcode_i      = stbs_pkg::OP_LOAD;
  logic        [stbs_pkg::IDX_W-1:0]  entry_index_i = '0;
  logic signed [stbs_pkg::VAL_W-1:0]  entry_value_i = '0;
  logic signed [stbs_pkg::VAL_W-1:0]  search_key_i  = '0;
  logic                               out_valid_o;
  logic                               out_ready_i   = 1'b0;
  logic signed [stbs_pkg::POS_W-1:0]  position_o;
  logic                               found_o;

  int error_count;
  int pending;
  int loaded_q [DEPTH];
  bit steady;
  int ready_left;
  int roll;
  int r;
  int n;

  always #10 clk_i = ~clk_i;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .search_key_i (search_key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .position_o   (position_o),
    .found_o      (found_o)
  );

  stbs_search_checker search_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .search_key_i (search_key_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .position_i   (position_o),
    .found_i      (found_o),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready_i <= 1'b1;
        ready_left = $urandom_range(0, 4);
      end else if (roll < 92) begin
        out_ready_i <= 1'b0;
        ready_left = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        ready_left = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int pick_key(int live);
    int k;
    int i;
    k = $urandom_range(0, 99);
    if (live == 0 || k < 15) return $urandom;
    i = $urandom_range(0, live - 1);
    if (k < 55) return loaded_q[i];
    if (k < 72) return loaded_q[i] + 1;
    if (k < 89) return loaded_q[i] - 1;
    if (k < 95) return VAL_LO;
    return VAL_HI;
  endfunction

  task automatic send_word(stbs_pkg::opcode_e op, int idx, int val, int key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= stbs_pkg::IDX_W'(idx);
    entry_value_i <= val;
    search_key_i  <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_entry(int idx, int val);
    if (idx < DEPTH) loaded_q[idx] = val;
    send_word(stbs_pkg::OP_LOAD, idx, val, $urandom);
  endtask

  task automatic search(stbs_pkg::opcode_e op, int key);
    send_word(op, $urandom_range(0, DEPTH - 1), $urandom, key);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic set_count(int c);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= stbs_pkg::CNT_W'(c);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // ascending fill with a random step size, or random values when not ordered; clamp at the top of the range
  task automatic fill_table(int size, bit ordered);
    longint v;
    int     step_max;
    r = $urandom_range(0, 2);
    step_max = (r == 0) ? 2 : (r == 1) ? 100 : (1 << 22);
    v = $urandom_range(0, 1) ? longint'(int'($urandom))
                             : longint'(VAL_LO) + $urandom_range(0, 1000);
    for (int i = 0; i < size; i++) begin
      if (ordered) begin
        load_entry(i, int'(v));
        v = v + $urandom_range(0, step_max);
        if (v > VAL_HI) v = VAL_HI;
      end else begin
        load_entry(i, $urandom);
      end
    end
  endtask

  task automatic search_burst(int count, int live);
    int idx;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, DEPTH - 1);
        load_entry(idx, $urandom);
      end else begin
        search(stbs_pkg::opcode_e'($urandom_range(stbs_pkg::OP_EXACT, stbs_pkg::OP_CEIL)),
               pick_key(live));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight out of reset
    search(stbs_pkg::OP_EXACT, 0);
    search(stbs_pkg::OP_FLOOR, VAL_LO);
    search(stbs_pkg::OP_CEIL, VAL_HI);

    load_entry(0, VAL_LO);
    load_entry(1, -1000);
    load_entry(2, -5);
    load_entry(3, 0);
    load_entry(4, 0);
    load_entry(5, 7);
    load_entry(6, 100);
    load_entry(7, VAL_HI);
    load_entry(DEPTH - 1, -77);
    set_count(8);
    search(stbs_pkg::OP_EXACT, VAL_LO);
    search(stbs_pkg::OP_EXACT, VAL_HI);
    search(stbs_pkg::OP_EXACT, 0);
    search(stbs_pkg::OP_EXACT, 3);
    search(stbs_pkg::OP_FLOOR, VAL_LO);
    search(stbs_pkg::OP_FLOOR, 6);
    search(stbs_pkg::OP_FLOOR, VAL_HI);
    search(stbs_pkg::OP_CEIL, VAL_LO);
    search(stbs_pkg::OP_CEIL, 101);
    search(stbs_pkg::OP_CEIL, -6);
    set_count(0);
    search(stbs_pkg::OP_CEIL, 0);
    search(stbs_pkg::OP_FLOOR, 0);

    repeat (8) begin
      r = $urandom_range(0, 99);
      n = (r < 5) ? 0 : (r < 25) ? $urandom_range(1, 3) :
          (r < 75) ? $urandom_range(4, 32) : $urandom_range(33, 128);
      set_count(n);
      steady = ($urandom_range(0, 3) == 0);
      fill_table(n, $urandom_range(0, 4) != 0);
      search_burst($urandom_range(20, 40), n);
    end

    set_count(DEPTH);
    steady = 1'b0;
    fill_table(DEPTH, 1'b1);
    search_burst(60, DEPTH);
    set_count(2047);
    steady = 1'b1;
    search_burst(40, DEPTH);
    set_count(DEPTH + 1);
    steady = 1'b0;
    search_burst(20, DEPTH);
    set_count(DEPTH - 1);
    search_burst(30, DEPTH - 1);

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
